>>> rtl/mpow_pkg.sv
// Package for the matrix power block: shared types, constants and helpers.
package mpow_pkg;

	localparam int ADDR_W  = 6;
	localparam int CNT_W   = 7;
	localparam int IDX_W   = 3;
	localparam int SIZE_W  = 4;
	localparam int DATA_W  = 64;
	localparam int EXP_W   = 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_DECIDE,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_MAC_WR,
		ST_COPY,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_SHOW
	} state_t;

	typedef enum logic {
		OP_SQUARE,
		OP_MULACC
	} op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_raddr_a;
		logic [ADDR_W-1:0] base_raddr_b;
		logic              base_we;
		logic [ADDR_W-1:0] base_waddr;
		logic              base_wsel_copy;
		logic [ADDR_W-1:0] acc_raddr;
		logic              acc_we;
		logic [ADDR_W-1:0] acc_waddr;
		logic              acc_wsel_copy;
		logic              acc_wbit;
		logic [ADDR_W-1:0] scr_raddr;
		logic              scr_we;
		logic [ADDR_W-1:0] scr_waddr;
		logic              right_sel_acc;
		logic              mul_en;
		logic              sum_clr;
		logic              sum_en;
		logic              out_load;
	} cmd_t;

	// Split a load position into row and column for a size of at most eight.
	function automatic logic [5:0] load_rc(input logic [5:0] pos, input logic [3:0] n);
		logic [2:0] q;
		logic [5:0] qn;
		logic [5:0] rem;
		q = '0;
		for (int k = 1; k < 8; k++) begin
			if (7'(k) * {3'b000, n} <= {1'b0, pos}) q = q + 3'd1;
		end
		qn = {3'b000, q} * {2'b00, n};
		rem = pos - qn;
		return {q, rem[2:0]};
	endfunction

endpackage

>>> rtl/matrix_power_by_squaring.sv
// Matrix power by squaring: elements are loaded while idle, then the identity is written to the accumulator.
// Each product takes a decision step, a sweep on the shared multiply-accumulate unit and a
// copy back from scratch; a job runs one squaring per exponent bit below the
// leading one plus one product per set bit, then a final decision before output.
// Each result is read, registered and shown, and held while the output stalls; input stalls until the last result.
// Reset clears control state and sets size 1; matrix stores are not cleared.
module matrix_power_by_squaring #(
	parameter int MAX_DIM = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [3:0]         cfg_write_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [63:0] element_value,
	input  logic [31:0]        exponent,
	input  logic               last_element,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] result_value,
	output logic [2:0]         result_row,
	output logic [2:0]         result_col,
	output logic               result_last
);
	import mpow_pkg::*;

	cmd_t cmd;

	mpow_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.exponent(exponent), .last_element(last_element),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_row(result_row), .result_col(result_col), .result_last(result_last),
		.cmd(cmd)
	);

	mpow_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk(clk), .cmd(cmd),
		.element_value(element_value), .result_value(result_value)
	);

`ifndef SYNTHESIS
	// No result is offered while input is taken
	assert property (@(posedge clk) disable iff (!arst_n) !in_stall |-> !out_valid)
		else $error("result offered while accepting input");
	// The last result ends the job
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_last |=> !out_valid && !in_stall)
		else $error("job did not end after last result");
	// The last element sits on the diagonal
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_last |-> result_row == result_col)
		else $error("last result off the diagonal");
`endif

endmodule

>>> rtl/mpow_ram.sv
// Generic RAM: one write port, two registered read ports.
module mpow_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                         rdata_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read with registered data
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> rtl/mpow_datapath.sv
// Datapath: matrix stores, shared multiply-accumulate unit and output register.
module mpow_datapath #(
	parameter int MAX_DIM = 8
) (
	input  logic                       clk,
	input  mpow_pkg::cmd_t             cmd,
	input  logic signed [63:0]         element_value,
	output logic signed [63:0]         result_value
);
	import mpow_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] base_rdata_a, base_rdata_b, acc_rdata, scr_rdata, scr_unused;
	logic [DATA_W-1:0] acc_unused;
	logic [DATA_W-1:0] base_wdata, acc_wdata, right_op;
	logic [DATA_W-1:0] prod_lo_s1;
	logic [31:0]       cross_a_s1, cross_b_s1;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] out_value_q;

	// Select write data for the two working stores
	assign base_wdata = cmd.base_wsel_copy ? scr_rdata : element_value;
	assign acc_wdata  = cmd.acc_wsel_copy ? scr_rdata : {63'b0, cmd.acc_wbit};

	mpow_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_base (
		.clk(clk), .we(cmd.base_we), .waddr(cmd.base_waddr[AW-1:0]), .wdata(base_wdata),
		.raddr_a(cmd.base_raddr_a[AW-1:0]), .rdata_a(base_rdata_a),
		.raddr_b(cmd.base_raddr_b[AW-1:0]), .rdata_b(base_rdata_b)
	);

	mpow_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_accum (
		.clk(clk), .we(cmd.acc_we), .waddr(cmd.acc_waddr[AW-1:0]), .wdata(acc_wdata),
		.raddr_a(cmd.acc_raddr[AW-1:0]), .rdata_a(acc_rdata),
		.raddr_b(cmd.acc_raddr[AW-1:0]), .rdata_b(acc_unused)
	);

	mpow_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_scratch (
		.clk(clk), .we(cmd.scr_we), .waddr(cmd.scr_waddr[AW-1:0]), .wdata(sum_q),
		.raddr_a(cmd.scr_raddr[AW-1:0]), .rdata_a(scr_rdata),
		.raddr_b(cmd.scr_raddr[AW-1:0]), .rdata_b(scr_unused)
	);

	assign right_op = cmd.right_sel_acc ? acc_rdata : base_rdata_b;

	// Form the partial products of the 32-bit halves for the wrapped 64-bit product
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_lo_s1 <= {32'b0, base_rdata_a[31:0]} * {32'b0, right_op[31:0]};
			cross_a_s1 <= base_rdata_a[31:0] * right_op[63:32];
			cross_b_s1 <= base_rdata_a[63:32] * right_op[31:0];
		end
	end

	// Accumulate the dot product
	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.sum_en) begin
			sum_q <= sum_q + prod_lo_s1 + {cross_a_s1 + cross_b_s1, 32'b0};
		end
	end

	// Hold the result element for the output transaction
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_value_q <= acc_rdata;
	end

	assign result_value = out_value_q;

endmodule

>>> rtl/mpow_ctrl.sv
// Controller: load sequencing, exponent loop, product sweep and result output.
module mpow_ctrl #(
	parameter int MAX_DIM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [3:0]                  cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 exponent,
	input  logic                        last_element,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  result_row,
	output logic [2:0]                  result_col,
	output logic                        result_last,
	output mpow_pkg::cmd_t              cmd
);
	import mpow_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	state_t state_q, state_d;
	op_t    op_q;
	logic [SIZE_W-1:0] size_q, n;
	logic [IDX_W-1:0]  r_q, c_q, k_q, nm1;
	logic [CNT_W-1:0]  cnt_q, total;
	logic [ADDR_W-1:0] pos_q, eff_pos, next_pos;
	logic [5:0]        rc;
	logic [EXP_W-1:0]  exp_q;
	logic              accept, k_last, c_last, r_last, copy_done;

	function automatic logic [ADDR_W-1:0] addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return ADDR_W'(int'(row) * MAX_DIM + int'(col));
	endfunction

	// Clamp the size register to the supported range
	always_comb begin
		if (size_q == '0) n = 4'd1;
		else if (size_q > SIZE_W'(MAX_DIM)) n = SIZE_W'(MAX_DIM);
		else n = size_q;
	end
	assign nm1   = IDX_W'(n - 4'd1);
	assign total = CNT_W'({3'b000, n} * {3'b000, n});

	// Load position: restart when beyond the matrix, wrap at its end
	assign eff_pos  = ({1'b0, pos_q} >= total) ? '0 : pos_q;
	assign next_pos = ({1'b0, eff_pos} + 7'd1 >= total) ? '0 : eff_pos + 6'd1;
	assign rc       = load_rc(eff_pos, n);

	assign accept    = in_valid && !in_stall;
	assign k_last    = (k_q == nm1);
	assign c_last    = (c_q == nm1);
	assign r_last    = (r_q == nm1);
	assign copy_done = (cnt_q == CNT_W'(DEPTH));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept && last_element) state_d = ST_INIT;
			ST_INIT:     if (r_last && c_last) state_d = ST_DECIDE;
			ST_DECIDE:   state_d = (exp_q == '0) ? ST_OUT_RD : ST_MAC_RD;
			ST_MAC_RD:   state_d = ST_MAC_MUL;
			ST_MAC_MUL:  state_d = ST_MAC_ACC;
			ST_MAC_ACC:  state_d = k_last ? ST_MAC_WR : ST_MAC_RD;
			ST_MAC_WR:   state_d = (r_last && c_last) ? ST_COPY : ST_MAC_RD;
			ST_COPY:     if (copy_done) state_d = ST_DECIDE;
			ST_OUT_RD:   state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: state_d = ST_OUT_SHOW;
			ST_OUT_SHOW: begin
				if (!out_stall) state_d = (r_last && c_last) ? ST_IDLE : ST_OUT_RD;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd = '0;
		cmd.base_raddr_a  = addr(r_q, k_q);
		cmd.base_raddr_b  = addr(k_q, c_q);
		cmd.acc_raddr     = (state_q inside {ST_OUT_RD}) ? addr(r_q, c_q) : addr(k_q, c_q);
		cmd.right_sel_acc = (op_q == OP_MULACC);
		cmd.scr_raddr     = cnt_q[ADDR_W-1:0];
		cmd.scr_waddr     = addr(r_q, c_q);
		cmd.base_waddr    = addr(rc[5:3], rc[2:0]);
		cmd.acc_waddr     = addr(r_q, c_q);
		cmd.acc_wbit      = (r_q == c_q);
		case (state_q)
			ST_IDLE:     cmd.base_we = accept;
			ST_INIT:     cmd.acc_we = 1'b1;
			ST_DECIDE:   cmd.sum_clr = 1'b1;
			ST_MAC_MUL:  cmd.mul_en = 1'b1;
			ST_MAC_ACC:  cmd.sum_en = 1'b1;
			ST_MAC_WR: begin
				cmd.scr_we  = 1'b1;
				cmd.sum_clr = 1'b1;
			end
			ST_COPY: begin
				cmd.base_wsel_copy = 1'b1;
				cmd.acc_wsel_copy  = 1'b1;
				cmd.base_waddr     = ADDR_W'(cnt_q - 7'd1);
				cmd.acc_waddr      = ADDR_W'(cnt_q - 7'd1);
				cmd.base_we        = (cnt_q != '0) && (op_q == OP_SQUARE);
				cmd.acc_we         = (cnt_q != '0) && (op_q == OP_MULACC);
			end
			ST_OUT_WAIT: cmd.out_load = 1'b1;
			default:     cmd.mul_en = 1'b0;
		endcase
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT_SHOW);
	assign result_row  = r_q;
	assign result_col  = c_q;
	assign result_last = r_last && c_last;

	// Advance state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SQUARE;
			size_q  <= 4'd1;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			exp_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) size_q <= cfg_write_data;
			case (state_q)
				ST_IDLE: begin
					r_q <= '0;
					c_q <= '0;
					if (accept) begin
						if (last_element) begin
							pos_q <= '0;
							exp_q <= exponent;
						end else begin
							pos_q <= next_pos;
						end
					end
				end
				ST_INIT: begin
					c_q <= c_last ? '0 : c_q + 3'd1;
					if (c_last) r_q <= r_last ? '0 : r_q + 3'd1;
				end
				ST_DECIDE: begin
					r_q   <= '0;
					c_q   <= '0;
					k_q   <= '0;
					cnt_q <= '0;
					op_q  <= exp_q[0] ? OP_MULACC : OP_SQUARE;
				end
				ST_MAC_ACC: k_q <= k_last ? '0 : k_q + 3'd1;
				ST_MAC_WR: begin
					c_q <= c_last ? '0 : c_q + 3'd1;
					if (c_last) r_q <= r_last ? '0 : r_q + 3'd1;
				end
				ST_COPY: begin
					cnt_q <= cnt_q + 7'd1;
					if (copy_done) begin
						exp_q <= (op_q == OP_MULACC) ? exp_q - 32'd1 : exp_q >> 1;
					end
				end
				ST_OUT_SHOW: begin
					if (!out_stall) begin
						c_q <= c_last ? '0 : c_q + 3'd1;
						if (c_last) r_q <= r_last ? '0 : r_q + 3'd1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sim/tb.sv
// Testbench for matrix_power_by_squaring: directed and random jobs checked against a predictor.
`timescale 1ns / 100ps

module tb;

	typedef struct {
		logic signed [63:0] value;
		logic [2:0]         row;
		logic [2:0]         col;
		logic               last;
	} elem_result_t;

	localparam int DIM = 8;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [3:0]         cfg_write_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [63:0] element_value;
	logic [31:0]        exponent;
	logic               last_element;
	logic               out_valid;
	logic               out_stall;
	logic signed [63:0] result_value;
	logic [2:0]         result_row;
	logic [2:0]         result_col;
	logic               result_last;

	// Predictor state
	logic [63:0] base_mat [DIM*DIM];
	logic [63:0] acc_mat [DIM*DIM];
	logic [63:0] scr_mat [DIM*DIM];
	logic [63:0] base_known;
	logic [63:0] scr_known;
	logic [3:0]  size_reg;
	logic [5:0]  load_pos;

	elem_result_t power_q[$];
	int          fail_count;
	int          items_sent;
	bit          calm;
	int          out_hold;

	matrix_power_by_squaring DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.element_value  (element_value),
		.exponent       (exponent),
		.last_element   (last_element),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.result_row     (result_row),
		.result_col     (result_col),
		.result_last    (result_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up after a generous time
	initial begin
		#40ms;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int dim_now();
		int n;
		n = size_reg;
		if (n == 0) n = 1;
		if (n > DIM) n = DIM;
		return n;
	endfunction

	function automatic logic [63:0] region_mask(int n);
		logic [63:0] m;
		m = '0;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				m[r*DIM+c] = 1'b1;
		return m;
	endfunction

	// scratch = left * right over the n by n corner
	task automatic mat_product(input bit right_is_acc, input int n);
		logic [63:0] sum;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				sum = '0;
				for (int k = 0; k < n; k++)
					sum += base_mat[r*DIM+k] *
						(right_is_acc ? acc_mat[k*DIM+c] : base_mat[k*DIM+c]);
				scr_mat[r*DIM+c] = sum;
			end
		scr_known |= region_mask(n);
	endtask

	// Update the predicted state for one accepted transaction; queue any results
	task automatic predict_power(input logic [63:0] elem, input logic [31:0] expo,
			input logic last);
		int n;
		int pos;
		logic [31:0] rem;
		elem_result_t res;
		n = dim_now();
		pos = load_pos;
		if (pos >= n*n) pos = 0;
		base_mat[(pos/n)*DIM + pos%n] = elem;
		base_known[(pos/n)*DIM + pos%n] = 1'b1;
		if (!last) begin
			pos++;
			if (pos >= n*n) pos = 0;
			load_pos = pos;
		end else begin
			load_pos = '0;
			rem = expo;
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++)
					acc_mat[r*DIM+c] = (r == c) ? 64'd1 : 64'd0;
			while (rem != 0) begin
				if (!rem[0]) begin
					mat_product(1'b0, n);
					base_mat = scr_mat;
					base_known = scr_known;
					rem = rem >> 1;
				end else begin
					mat_product(1'b1, n);
					acc_mat = scr_mat;
					rem = rem - 1;
				end
			end
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++) begin
					res.value = acc_mat[r*DIM+c];
					res.row = r[2:0];
					res.col = c[2:0];
					res.last = (r == n-1) && (c == n-1);
					power_q.push_back(res);
				end
		end
	endtask

	// Send one transaction after a random gap (none when calm); predict it when accepted
	task automatic send_item(input logic [63:0] elem, input logic [31:0] expo,
			input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= elem;
		exponent <= expo;
		last_element <= last;
		forever begin
			@(negedge clk);
			if (!in_stall) break;
		end
		@(posedge clk);
		predict_power(elem, expo, last);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (power_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write the size register once the block is idle
	task automatic set_size(input logic [3:0] sz);
		drain_results();
		cfg_write_en <= 1'b1;
		cfg_write_data <= sz;
		@(posedge clk);
		size_reg = sz;
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [63:0] rand_elem();
		case ($urandom_range(0, 3))
			0: return {$urandom, $urandom};
			1: return 64'($signed($urandom_range(0, 6)) - 3);
			default: return 64'($urandom_range(0, 5));
		endcase
	endfunction

	// Complete the current load with random elements, then start the job
	task automatic finish_load(input logic [31:0] expo);
		int n;
		n = dim_now();
		while (load_pos != n*n - 1 && n != 1)
			send_item(rand_elem(), $urandom, 1'b0);
		send_item(rand_elem(), expo, 1'b1);
	endtask

	task automatic test_reset_size();
		send_item(64'h7fff_ffff_ffff_ffff, 32'd5, 1'b1);
	endtask

	task automatic test_size_extremes();
		set_size(4'd0);
		send_item(64'h8000_0000_0000_0000, 32'd0, 1'b1);
		send_item(64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1);
		set_size(4'd2);
		send_item(64'h8000_0000_0000_0000, 32'd0, 1'b0);
		send_item(64'h7fff_ffff_ffff_ffff, 32'd0, 1'b0);
		send_item(64'd3, 32'd0, 1'b0);
		send_item(64'hffff_ffff_ffff_fffe, 32'd2, 1'b1);
	endtask

	task automatic test_wrap_and_early();
		// Overrun the load so it wraps and overwrites from the start
		for (int i = 0; i < 5; i++)
			send_item(64'(i + 1), 32'd0, 1'b0);
		send_item(64'd7, 32'd3, 1'b1);
		// Last mark on the first slot: other entries carry over
		send_item(64'd2, 32'd1, 1'b1);
	endtask

	task automatic test_position_beyond();
		set_size(4'd3);
		for (int i = 0; i < 5; i++)
			send_item(64'(i), 32'd0, 1'b0);
		set_size(4'd2);
		send_item(64'd9, 32'd4, 1'b1);
	endtask

	task automatic test_pause();
		set_size(4'd1);
		send_item(64'd3, 32'd7, 1'b1);
		drain_results();
		calm = 1'b1;
		send_item(64'd2, 32'd3, 1'b1);
		send_item(64'd5, 32'd2, 1'b1);
		calm = 1'b0;
	endtask

	task automatic test_random();
		int n;
		int noise;
		logic [31:0] expo;
		// One full-size job with the largest exponent
		set_size(4'd15);
		finish_load(32'hffff_ffff);
		while (items_sent < 100) begin
			if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 5) == 0) set_size(4'($urandom_range(4, 8)));
				else set_size(4'($urandom_range(0, 3)));
			end
			calm = ($urandom_range(0, 4) == 0);
			n = dim_now();
			if ($urandom_range(0, 3) == 0) expo = $urandom_range(0, 3);
			else if (n <= 2) expo = $urandom;
			else if (n <= 4) expo = $urandom_range(0, 5000);
			else expo = $urandom_range(0, 200);
			if ($urandom_range(0, 4) == 0) begin
				// Noise: partial or overrunning load, early last when it is safe
				noise = $urandom_range(0, 2*n*n);
				for (int i = 0; i < noise; i++)
					send_item(rand_elem(), $urandom, 1'b0);
				if ((base_known & region_mask(n)) == region_mask(n))
					send_item(rand_elem(), expo, 1'b1);
				else
					finish_load(expo);
			end else begin
				finish_load(expo);
			end
		end
		calm = 1'b0;
	endtask

	// Receiver stall: a random hold after each transaction
	always @(posedge clk) begin
		int nxt;
		nxt = out_hold;
		if (out_valid && !out_stall) nxt = calm ? 0 : $urandom_range(0, 10);
		else if (nxt > 0) nxt--;
		out_hold <= nxt;
		out_stall <= (nxt != 0);
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		elem_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (power_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value %0d row %0d col %0d last %0b",
						result_value, result_row, result_col, result_last);
			end else begin
				want = power_q.pop_front();
				if (want.value !== result_value || want.row !== result_row ||
						want.col !== result_col || want.last !== result_last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: exp %0d r%0d c%0d l%0b got %0d r%0d c%0d l%0b",
							want.value, want.row, want.col, want.last,
							result_value, result_row, result_col, result_last);
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		items_sent = 0;
		calm = 1'b0;
		out_hold = 0;
		size_reg = 4'd1;
		load_pos = '0;
		base_known = '0;
		scr_known = '0;
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		in_valid <= 1'b0;
		element_value <= '0;
		exponent <= '0;
		last_element <= 1'b0;
		out_stall <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_size_extremes();
		test_wrap_and_early();
		test_position_beyond();
		test_pause();
		test_random();
		drain_results();
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/mpow_pkg.sv
rtl/mpow_ram.sv
rtl/mpow_datapath.sv
rtl/mpow_ctrl.sv
rtl/matrix_power_by_squaring.sv
sim/tb.sv
